FILE: sv/lats_pkg.sv
// Shared types and constants for the toroidal life automaton block.
package lats_pkg;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT = 64;

   localparam int FUNC_W      = 2;
   localparam int ROW_IDX_W   = 6;
   localparam int CELLS_W     = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd1;

   localparam logic [CSR_DATA_W-1:0] GRID_HEIGHT_RESET = 7'd64;
   localparam logic [CSR_DATA_W-1:0] GRID_WIDTH_RESET  = 7'd64;

   // Rule B3/S23: neighbor counts for birth and survival.
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_ADVANCE = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_ADVANCE,
      ST_RESP
   } state_type;

   // Three vertically adjacent cell bits of one column.
   typedef struct packed {
      logic up;
      logic mid;
      logic dn;
   } col_type;

endpackage

FILE: sv/lats_cell.sv
// One column cell: holds a three-row window and computes the next state of its middle bit.
module lats_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              bit_in,
   input  lats_pkg::col_type left_col,
   input  lats_pkg::col_type right_col,
   output lats_pkg::col_type col,
   output logic              next_alive
);

   lats_pkg::col_type col_ff;
   lats_pkg::col_type col_in;
   logic [3:0]        count;

   always_comb begin
      col_in = col_ff;
      if (shift_en) begin
         col_in = '{up: col_ff.mid, mid: col_ff.dn, dn: bit_in};
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign count = 4'(left_col.up) + 4'(left_col.mid) + 4'(left_col.dn)
                + 4'(col_ff.up) + 4'(col_ff.dn)
                + 4'(right_col.up) + 4'(right_col.mid) + 4'(right_col.dn);

   assign next_alive = (count == lats_pkg::BIRTH_COUNT)
                     || (col_ff.mid && (count == lats_pkg::SURVIVE_COUNT));
   assign col        = col_ff;

endmodule

FILE: sv/lats_chain.sv
// Row of column cells with horizontal wrap at the configured grid width.
module lats_chain #(
   parameter int MAX_COLS = lats_pkg::MAX_COLS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               shift_en,
   input  logic [MAX_COLS-1:0]                row_in,
   input  logic [$clog2(MAX_COLS + 1)-1:0]    eff_w,
   output logic [MAX_COLS-1:0]                next_row
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   lats_pkg::col_type col_q [MAX_COLS];
   lats_pkg::col_type wrap_col;
   logic [COL_W-1:0]  last_col;

   // The last column in use is the left neighbor of column zero.
   assign last_col = COL_W'(eff_w - 1'b1);
   assign wrap_col = col_q[last_col];

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
      lats_pkg::col_type left_col;
      lats_pkg::col_type right_col;

      if (j == 0) begin : g_left_wrap
         assign left_col = wrap_col;
      end else begin : g_left
         assign left_col = col_q[j-1];
      end

      if (j == MAX_COLS - 1) begin : g_right_wrap
         assign right_col = col_q[0];
      end else begin : g_right
         assign right_col = (last_col == COL_W'(j)) ? col_q[0] : col_q[j+1];
      end

      lats_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .bit_in     (row_in[j]),
         .left_col   (left_col),
         .right_col  (right_col),
         .col        (col_q[j]),
         .next_alive (next_row[j])
      );
   end

endmodule

FILE: sv/life_automaton_torus_step_top.sv
// Top level of the toroidal life automaton: row memory, sequencer and result register.
//
// Items arrive on the req_ channel (func, row index, row cells) and each yields exactly
// one result item on the rsp_ channel (echoed func, row bits for a read). Both use
// valid/ready. The block works on one item at a time; req_ready is high only while
// idle, and a finished result waits in an output register, so a new item is taken
// while the previous result is still held by a stalled receiver. A further result
// then waits inside the block until the output register is free.
// A write or read passes through its own state before the result register is loaded;
// a no-op goes straight to that step. An advance sweeps the row memory one row per
// cycle through its single write port, once the three-row window held in the column
// cells has been filled; rows past the grid height are written as zero.
// Reset (synchronous) sets both grid dimensions to 64, selects bank zero and starts
// a clearing pass over all 2 * MAX_ROWS rows that zeroes the row memory; no item is
// accepted until it ends. Register writes on csr_ are taken at any time, but are
// only meant to change while the block is idle.
module life_automaton_torus_step_top #(
   parameter int MAX_ROWS = lats_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = lats_pkg::MAX_COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lats_pkg::FUNC_W-1:0]         req_func,
   input  logic [lats_pkg::ROW_IDX_W-1:0]      req_row_index,
   input  logic [lats_pkg::CELLS_W-1:0]        req_row_cells,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lats_pkg::FUNC_W-1:0]         rsp_done_func,
   output logic [lats_pkg::CELLS_W-1:0]        rsp_read_cells,
   input  logic                                csr_we,
   input  logic [lats_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lats_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int RD_CNT_W  = $clog2(MAX_ROWS + 3);
   localparam int DEPTH     = 2 * MAX_ROWS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

   // Row memory: bank zero in the lower half, bank one in the upper half.
   logic [MAX_COLS-1:0] mem [DEPTH];
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                mem_we;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [MAX_COLS-1:0] mem_wdata;

   lats_pkg::state_type state_ff, state_in;
   logic                bank_ff, bank_in;
   logic [lats_pkg::CSR_DATA_W-1:0] height_ff, height_in;
   logic [lats_pkg::CSR_DATA_W-1:0] width_ff, width_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [ROW_W-1:0]    rd_row_ff, rd_row_in;
   logic [RD_CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic                rdv_ff, rdv_in;
   logic [1:0]          sh_cnt_ff, sh_cnt_in;
   logic                win_new_ff, win_new_in;
   logic [ROW_W-1:0]    wr_row_ff, wr_row_in;
   logic                rsp_valid_ff, rsp_valid_in;

   lats_pkg::func_type  op_func_ff, op_func_in;
   logic [lats_pkg::ROW_IDX_W-1:0] op_row_ff, op_row_in;
   logic [MAX_COLS-1:0] op_cells_ff, op_cells_in;
   logic [lats_pkg::FUNC_W-1:0]  rsp_func_ff, rsp_func_in;
   logic [lats_pkg::CELLS_W-1:0] rsp_cells_ff, rsp_cells_in;

   logic [ROW_CNT_W-1:0] eff_h;
   logic [COL_CNT_W-1:0] eff_w;
   logic [ROW_W-1:0]     h_last;
   logic [MAX_COLS-1:0]  col_mask;
   logic                 op_row_ok;
   logic [ADDR_W-1:0]    cur_base;
   logic [ADDR_W-1:0]    oth_base;
   logic [ADDR_W-1:0]    op_addr;
   logic                 rd_more;
   logic                 wr_live;
   logic                 shift_en;
   logic [MAX_COLS-1:0]  next_row;

   // Out-of-range dimensions clamp to the nearest legal value.
   always_comb begin
      if (height_ff == '0) begin
         eff_h = ROW_CNT_W'(1);
      end else if (32'(height_ff) > 32'(MAX_ROWS)) begin
         eff_h = ROW_CNT_W'(MAX_ROWS);
      end else begin
         eff_h = ROW_CNT_W'(height_ff);
      end
      if (width_ff == '0) begin
         eff_w = COL_CNT_W'(1);
      end else if (32'(width_ff) > 32'(MAX_COLS)) begin
         eff_w = COL_CNT_W'(MAX_COLS);
      end else begin
         eff_w = COL_CNT_W'(width_ff);
      end
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (32'(j) < 32'(eff_w));
      end
   end

   assign h_last    = ROW_W'(eff_h - 1'b1);
   assign op_row_ok = (32'(op_row_ff) < 32'(eff_h));
   assign cur_base  = bank_ff ? ADDR_W'(MAX_ROWS) : '0;
   assign oth_base  = bank_ff ? '0 : ADDR_W'(MAX_ROWS);
   assign op_addr   = cur_base + ADDR_W'(op_row_ff);
   assign rd_more   = (32'(rd_cnt_ff) < (32'(eff_h) + 32'd2));
   assign wr_live   = (32'(wr_row_ff) < 32'(eff_h));

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      clr_in       = clr_ff;
      rd_row_in    = rd_row_ff;
      rd_cnt_in    = rd_cnt_ff;
      rdv_in       = rdv_ff;
      sh_cnt_in    = sh_cnt_ff;
      win_new_in   = win_new_ff;
      wr_row_in    = wr_row_ff;
      rsp_valid_in = rsp_valid_ff;
      op_func_in   = op_func_ff;
      op_row_in    = op_row_ff;
      op_cells_in  = op_cells_ff;
      rsp_func_in  = rsp_func_ff;
      rsp_cells_in = rsp_cells_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = '0;
      shift_en     = 1'b0;
      req_ready    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            lats_pkg::CSR_GRID_HEIGHT: height_in = csr_wdata;
            lats_pkg::CSR_GRID_WIDTH:  width_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lats_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = lats_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         lats_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_func_in  = lats_pkg::func_type'(req_func);
               op_row_in   = req_row_index;
               op_cells_in = req_row_cells[MAX_COLS-1:0];
               rd_row_in   = h_last;
               rd_cnt_in   = '0;
               rdv_in      = 1'b0;
               sh_cnt_in   = '0;
               win_new_in  = 1'b0;
               wr_row_in   = '0;
               case (lats_pkg::func_type'(req_func))
                  lats_pkg::FUNC_WRITE:   state_in = lats_pkg::ST_WRITE;
                  lats_pkg::FUNC_READ:    state_in = lats_pkg::ST_READ;
                  lats_pkg::FUNC_ADVANCE: state_in = lats_pkg::ST_ADVANCE;
                  default:                state_in = lats_pkg::ST_RESP;
               endcase
            end
         end
         lats_pkg::ST_WRITE: begin
            if (op_row_ok) begin
               mem_we    = 1'b1;
               mem_waddr = op_addr;
               mem_wdata = op_cells_ff & col_mask;
            end
            state_in = lats_pkg::ST_RESP;
         end
         lats_pkg::ST_READ: begin
            if (op_row_ok) begin
               mem_re    = 1'b1;
               mem_raddr = op_addr;
            end
            state_in = lats_pkg::ST_RESP;
         end
         lats_pkg::ST_ADVANCE: begin
            // Source rows stream as h-1, 0, 1, ..., h-1, 0 so that every window
            // holds the row above, the row itself and the row below with wrap.
            if (rd_more) begin
               mem_re    = 1'b1;
               mem_raddr = cur_base + ADDR_W'(rd_row_ff);
               rd_row_in = (rd_row_ff == h_last) ? '0 : rd_row_ff + 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            rdv_in = rd_more;
            if (rdv_ff) begin
               shift_en   = 1'b1;
               sh_cnt_in  = (sh_cnt_ff == 2'd3) ? sh_cnt_ff : sh_cnt_ff + 1'b1;
               win_new_in = (sh_cnt_ff >= 2'd2);
            end else begin
               win_new_in = 1'b0;
            end
            // Rows past the height are written with zeros once the live rows are done.
            if (!wr_live || win_new_ff) begin
               mem_we    = 1'b1;
               mem_waddr = oth_base + ADDR_W'(wr_row_ff);
               mem_wdata = wr_live ? (next_row & col_mask) : '0;
               if (wr_row_ff == ROW_W'(MAX_ROWS - 1)) begin
                  bank_in  = ~bank_ff;
                  state_in = lats_pkg::ST_RESP;
               end else begin
                  wr_row_in = wr_row_ff + 1'b1;
               end
            end
         end
         lats_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_func_in  = op_func_ff;
               rsp_cells_in = ((op_func_ff == lats_pkg::FUNC_READ) && op_row_ok)
                            ? lats_pkg::CELLS_W'(rd_data_ff & col_mask) : '0;
               state_in     = lats_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lats_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lats_pkg::ST_CLEAR;
         bank_ff      <= 1'b0;
         height_ff    <= lats_pkg::GRID_HEIGHT_RESET;
         width_ff     <= lats_pkg::GRID_WIDTH_RESET;
         clr_ff       <= '0;
         rd_row_ff    <= '0;
         rd_cnt_ff    <= '0;
         rdv_ff       <= 1'b0;
         sh_cnt_ff    <= '0;
         win_new_ff   <= 1'b0;
         wr_row_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         clr_ff       <= clr_in;
         rd_row_ff    <= rd_row_in;
         rd_cnt_ff    <= rd_cnt_in;
         rdv_ff       <= rdv_in;
         sh_cnt_ff    <= sh_cnt_in;
         win_new_ff   <= win_new_in;
         wr_row_ff    <= wr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_func_ff   <= op_func_in;
      op_row_ff    <= op_row_in;
      op_cells_ff  <= op_cells_in;
      rsp_func_ff  <= rsp_func_in;
      rsp_cells_ff <= rsp_cells_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   lats_chain #(
      .MAX_COLS (MAX_COLS)
   ) u_chain (
      .clock    (clock),
      .shift_en (shift_en),
      .row_in   (rd_data_ff),
      .eff_w    (eff_w),
      .next_row (next_row)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_done_func  = rsp_func_ff;
   assign rsp_read_cells = rsp_cells_ff;

   // An advance writes only the other bank and reads only the current one.
   a_adv_write_other_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lats_pkg::ST_ADVANCE && mem_we)
      |-> ((32'(mem_waddr) >= 32'(MAX_ROWS)) == !bank_ff))
      else $error("advance wrote into the current bank");

   a_adv_read_cur_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lats_pkg::ST_ADVANCE && mem_re)
      |-> ((32'(mem_raddr) >= 32'(MAX_ROWS)) == bank_ff))
      else $error("advance read from the next-generation bank");

   a_bank_flip_at_advance_end: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> ($past(state_ff) == lats_pkg::ST_ADVANCE))
      else $error("active bank changed outside an advance");

   a_window_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lats_pkg::ST_ADVANCE && win_new_ff) |-> (sh_cnt_ff == 2'd3))
      else $error("row written before the three-row window was filled");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in work");

endmodule

FILE: tb/life_grid_checker.sv
`timescale 1ns / 1ps
// Checker for the toroidal life automaton: watches both channels, predicts each result item and compares.
module life_grid_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [lats_pkg::FUNC_W-1:0]      req_func,
   input  logic [lats_pkg::ROW_IDX_W-1:0]   req_row_index,
   input  logic [lats_pkg::CELLS_W-1:0]     req_row_cells,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [lats_pkg::FUNC_W-1:0]      rsp_done_func,
   input  logic [lats_pkg::CELLS_W-1:0]     rsp_read_cells,
   input  logic                             csr_we,
   input  logic [lats_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lats_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               error_count,
   output int                               pending_count
);

   localparam int ROWS = lats_pkg::MAX_ROWS_DEFAULT;
   localparam int COLS = lats_pkg::MAX_COLS_DEFAULT;

   typedef struct packed {
      logic [lats_pkg::FUNC_W-1:0]  done_func;
      logic [lats_pkg::CELLS_W-1:0] read_cells;
   } outcome_type;

   outcome_type                    queued_outcomes[$];
   logic [lats_pkg::CELLS_W-1:0]    gen_rows [2][ROWS];
   logic                            live_bank;
   logic [lats_pkg::CSR_DATA_W-1:0] grid_height;
   logic [lats_pkg::CSR_DATA_W-1:0] grid_width;
   int                              mismatch_total = 0;
   int                              queued_total = 0;

   assign error_count   = mismatch_total;
   assign pending_count = queued_total;

   // A dimension of zero acts as one and anything past the array size is clipped.
   function automatic int dim_in_use(logic [lats_pkg::CSR_DATA_W-1:0] raw, int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return int'(raw);
   endfunction

   function automatic void next_generation();
      int h, w, i, j, l, r, n;
      logic [lats_pkg::CELLS_W-1:0] up, mid, dn, next;
      h = dim_in_use(grid_height, ROWS);
      w = dim_in_use(grid_width, COLS);
      for (i = 0; i < ROWS; i++) begin
         next = '0;
         if (i < h) begin
            up  = gen_rows[live_bank][(i + h - 1) % h];
            mid = gen_rows[live_bank][i];
            dn  = gen_rows[live_bank][(i + 1) % h];
            for (j = 0; j < w; j++) begin
               // On narrow or short grids the wrap makes some neighbors coincide.
               l = (j + w - 1) % w;
               r = (j + 1) % w;
               n = int'(up[l]) + int'(up[j]) + int'(up[r]) + int'(mid[l]) + int'(mid[r])
                 + int'(dn[l]) + int'(dn[j]) + int'(dn[r]);
               if (n == lats_pkg::BIRTH_COUNT
                   || (mid[j] && n == lats_pkg::SURVIVE_COUNT))
                  next[j] = 1'b1;
            end
         end
         gen_rows[~live_bank][i] = next;
      end
      live_bank = ~live_bank;
   endfunction

   function automatic outcome_type apply_item(logic [lats_pkg::FUNC_W-1:0] f,
                                              logic [lats_pkg::ROW_IDX_W-1:0] row,
                                              logic [lats_pkg::CELLS_W-1:0] cells);
      outcome_type o;
      int h, w;
      logic [lats_pkg::CELLS_W-1:0] m;
      h = dim_in_use(grid_height, ROWS);
      w = dim_in_use(grid_width, COLS);
      m = (w >= lats_pkg::CELLS_W) ? '1 : ((lats_pkg::CELLS_W'(1) << w) - 1);
      o.done_func  = f;
      o.read_cells = '0;
      case (f)
         lats_pkg::FUNC_WRITE: begin
            if (row < h) gen_rows[live_bank][row] = cells & m;
         end
         lats_pkg::FUNC_READ: begin
            if (row < h) o.read_cells = gen_rows[live_bank][row] & m;
         end
         lats_pkg::FUNC_ADVANCE: begin
            next_generation();
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int b = 0; b < 2; b++)
            for (int r = 0; r < ROWS; r++)
               gen_rows[b][r] = '0;
         live_bank   = 1'b0;
         grid_height = lats_pkg::GRID_HEIGHT_RESET;
         grid_width  = lats_pkg::GRID_WIDTH_RESET;
         queued_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (queued_outcomes.size() == 0) begin
               report_mismatch($sformatf("result item func %0d with nothing expected",
                                         rsp_done_func));
            end else begin
               want = queued_outcomes.pop_front();
               if (rsp_done_func !== want.done_func)
                  report_mismatch($sformatf("done_func %0d, expected %0d",
                                            rsp_done_func, want.done_func));
               if (rsp_read_cells !== want.read_cells)
                  report_mismatch($sformatf("read_cells %h, expected %h (func %0d)",
                                            rsp_read_cells, want.read_cells, want.done_func));
            end
         end
         if (csr_we) begin
            case (csr_index)
               lats_pkg::CSR_GRID_HEIGHT: grid_height = csr_wdata;
               lats_pkg::CSR_GRID_WIDTH:  grid_width  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            queued_outcomes.push_back(apply_item(req_func, req_row_index, req_row_cells));
      end
      queued_total <= queued_outcomes.size();
   end

endmodule

FILE: tb/life_automaton_torus_step_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the toroidal life automaton: stimulus, handshake idling and the verdict.
module life_automaton_torus_step_top_tb;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 1850;

   localparam logic [lats_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [lats_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [lats_pkg::FUNC_W-1:0]      req_func = lats_pkg::FUNC_NOP;
   logic [lats_pkg::ROW_IDX_W-1:0]   req_row_index = '0;
   logic [lats_pkg::CELLS_W-1:0]     req_row_cells = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [lats_pkg::FUNC_W-1:0]      rsp_done_func;
   logic [lats_pkg::CELLS_W-1:0]     rsp_read_cells;
   logic                             csr_we = 1'b0;
   logic [lats_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lats_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatches;
   int pending;
   int send_calm = 0;
   int recv_calm = 0;
   int idle_cycles = 0;
   int grid_rows = lats_pkg::MAX_ROWS_DEFAULT;

   life_automaton_torus_step_top dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_func, .req_row_index, .req_row_cells,
      .rsp_valid, .rsp_ready, .rsp_done_func, .rsp_read_cells,
      .csr_we, .csr_index, .csr_wdata
   );

   life_grid_checker grid_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_func, .req_row_index, .req_row_cells,
      .rsp_valid, .rsp_ready, .rsp_done_func, .rsp_read_cells,
      .csr_we, .csr_index, .csr_wdata,
      .error_count(mismatches), .pending_count(pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly random waits, broken up now and then by a run of items with no waiting.
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [lats_pkg::CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 7'd1;
         2:       return 7'd2;
         3:       return 7'd64;
         4:       return 7'($urandom_range(65, 127));
         5, 6:    return 7'($urandom_range(3, 8));
         default: return 7'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [lats_pkg::ROW_IDX_W-1:0] pick_row();
      if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, grid_rows - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   function automatic logic [lats_pkg::CELLS_W-1:0] random_cells();
      logic [lats_pkg::CELLS_W-1:0] a, b, c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       return a & b & c;
         1:       return a & b;
         2:       return a | b;
         3:       return '0;
         default: return a;
      endcase
   endfunction

   task automatic send_item(input lats_pkg::func_type f,
                            input logic [lats_pkg::ROW_IDX_W-1:0] row,
                            input logic [lats_pkg::CELLS_W-1:0] cells);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_row_index <= row;
      req_row_cells <= cells;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Both grid registers are written back to back, then an unused index that must be ignored.
   task automatic set_grid(input logic [lats_pkg::CSR_DATA_W-1:0] rows,
                           input logic [lats_pkg::CSR_DATA_W-1:0] cols);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= lats_pkg::CSR_GRID_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= lats_pkg::CSR_GRID_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= $urandom_range(0, 1) ? CSR_UNUSED_HI : CSR_UNUSED_LO;
      csr_wdata <= 7'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      grid_rows = (rows == 0) ? 1
                : (rows > lats_pkg::MAX_ROWS_DEFAULT) ? lats_pkg::MAX_ROWS_DEFAULT
                : int'(rows);
   endtask

   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_wait(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("life_automaton_torus_step_top_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_done;
      int phase_len;
      int pause_at;
      int sel;
      lats_pkg::func_type f;
      logic [lats_pkg::ROW_IDX_W-1:0] row;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Full 64 by 64 grid after reset: corners of the index range and of the cell word.
      send_item(lats_pkg::FUNC_READ, 6'd0, '0);
      send_item(lats_pkg::FUNC_WRITE, 6'd0, '1);
      send_item(lats_pkg::FUNC_WRITE, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(lats_pkg::FUNC_READ, 6'd0, '0);
      send_item(lats_pkg::FUNC_READ, 6'd63, '1);
      send_item(lats_pkg::FUNC_ADVANCE, 6'd63, '1);
      send_item(lats_pkg::FUNC_READ, 6'd0, '0);
      send_item(lats_pkg::FUNC_READ, 6'd62, '0);
      send_item(lats_pkg::FUNC_READ, 6'd63, '0);
      send_item(lats_pkg::FUNC_NOP, 6'd63, '1);

      // Zero in both registers gives a single cell that sees itself eight times.
      set_grid('0, '0);
      send_item(lats_pkg::FUNC_WRITE, 6'd0, '1);
      send_item(lats_pkg::FUNC_READ, 6'd0, '0);
      send_item(lats_pkg::FUNC_WRITE, 6'd5, '1);
      send_item(lats_pkg::FUNC_READ, 6'd5, '0);
      send_item(lats_pkg::FUNC_ADVANCE, 6'd0, '0);
      send_item(lats_pkg::FUNC_READ, 6'd0, '0);

      // Oversized values clip to the full grid; a blinker turns on its side.
      set_grid(7'd127, 7'd127);
      send_item(lats_pkg::FUNC_WRITE, 6'd10, 64'h70);
      send_item(lats_pkg::FUNC_ADVANCE, 6'd0, '0);
      send_item(lats_pkg::FUNC_READ, 6'd9, '0);
      send_item(lats_pkg::FUNC_READ, 6'd10, '0);
      send_item(lats_pkg::FUNC_READ, 6'd11, '0);

      // Two by two grid, where the row and column neighbors are counted twice and the diagonal one four times.
      set_grid(7'd2, 7'd2);
      send_item(lats_pkg::FUNC_WRITE, 6'd0, 64'h1);
      send_item(lats_pkg::FUNC_ADVANCE, 6'd0, '0);
      send_item(lats_pkg::FUNC_READ, 6'd0, '0);
      send_item(lats_pkg::FUNC_READ, 6'd1, '0);

      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         set_grid(pick_dim(), pick_dim());
         // Seed most rows of the grid before the mixed traffic starts.
         for (int r = 0; r < grid_rows && random_done < RANDOM_ITEMS; r++) begin
            if ($urandom_range(0, 3) != 0) begin
               send_item(lats_pkg::FUNC_WRITE, 6'(r), random_cells());
               random_done++;
            end
         end
         phase_len = $urandom_range(60, 200);
         pause_at  = $urandom_range(0, phase_len - 1);
         for (int k = 0; k < phase_len && random_done < RANDOM_ITEMS; k++) begin
            if (k == pause_at) wait_for_results();
            sel = $urandom_range(0, 99);
            row = pick_row();
            if (sel < 40)      f = lats_pkg::FUNC_WRITE;
            else if (sel < 75) f = lats_pkg::FUNC_READ;
            else if (sel < 94) f = lats_pkg::FUNC_ADVANCE;
            else               f = lats_pkg::FUNC_NOP;
            send_item(f, row, random_cells());
            random_done++;
         end
      end

      wait_for_results();
      repeat (lats_pkg::MAX_ROWS_DEFAULT + 10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("life_automaton_torus_step_top_tb: clean");
      end else begin
         $display("life_automaton_torus_step_top_tb: errors");
      end
      $finish;
   end

endmodule
